/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros shared by the unescaper modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define JSU_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off while reset is high
`define JSU_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg
// types, codes and helpers of the json string unescaper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jsu_pkg;

   // default depth of the queue between decoder and serialiser
   localparam int JSU_QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      ST_BYTE    = 3'd0,
      ST_CLOSED  = 3'd1,
      ST_NOQUOTE = 3'd2,
      ST_BADESC  = 3'd3,
      ST_BADHEX  = 3'd4,
      ST_UNTERM  = 3'd5,
      ST_AFTER   = 3'd6
   } status_type;

   // ascii characters the decoder looks for
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;

   // code point limits
   localparam logic [15:0] CP_HIGH_FIRST = 16'hD800;
   localparam logic [15:0] CP_HIGH_LAST  = 16'hDBFF;
   localparam logic [15:0] CP_LOW_FIRST  = 16'hDC00;
   localparam logic [15:0] CP_LOW_LAST   = 16'hDFFF;
   localparam logic [20:0] CP_REPLACE    = 21'h00FFFD;
   localparam logic [20:0] CP_SUPP_BASE  = 21'h010000;
   localparam logic [20:0] CP_ONE_MAX    = 21'h00007F;
   localparam logic [20:0] CP_TWO_MAX    = 21'h0007FF;
   localparam logic [20:0] CP_THREE_MAX  = 21'h00FFFF;

   // utf-8 lead and continuation marks
   localparam logic [7:0] U8_LEAD2 = 8'hC0;
   localparam logic [7:0] U8_LEAD3 = 8'hE0;
   localparam logic [7:0] U8_LEAD4 = 8'hF0;
   localparam logic [7:0] U8_CONT  = 8'h80;
   localparam logic [7:0] U8_MASK6 = 8'h3F;

   // up to four encoded bytes, b[0] goes out first
   typedef struct packed {
      logic [2:0]      len;
      logic [3:0][7:0] b;
   } utf8_type;

   // one decoded input item: bytes first, then an optional status
   typedef struct packed {
      logic [2:0]      nb;
      logic [5:0][7:0] bytes;
      logic            has_st;
      status_type      st;
   } rec_type;

   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type e;
      e = '0;
      if (cp <= CP_ONE_MAX) begin
         e.len  = 3'd1;
         e.b[0] = cp[7:0];
      end else if (cp <= CP_TWO_MAX) begin
         e.len  = 3'd2;
         e.b[0] = U8_LEAD2 | {3'b000, cp[10:6]};
         e.b[1] = U8_CONT | ({2'b00, cp[5:0]} & U8_MASK6);
      end else if (cp <= CP_THREE_MAX) begin
         e.len  = 3'd3;
         e.b[0] = U8_LEAD3 | {4'b0000, cp[15:12]};
         e.b[1] = U8_CONT | ({2'b00, cp[11:6]} & U8_MASK6);
         e.b[2] = U8_CONT | ({2'b00, cp[5:0]} & U8_MASK6);
      end else begin
         e.len  = 3'd4;
         e.b[0] = U8_LEAD4 | {5'b00000, cp[20:18]};
         e.b[1] = U8_CONT | ({2'b00, cp[17:12]} & U8_MASK6);
         e.b[2] = U8_CONT | ({2'b00, cp[11:6]} & U8_MASK6);
         e.b[3] = U8_CONT | ({2'b00, cp[5:0]} & U8_MASK6);
      end
      return e;
   endfunction

endpackage

/* hdl/jsu_front.sv */
// ----------------------------------------------------------------------------
// jsu_front
// escape decoder: takes one request a cycle while accept is high, folds it into a record
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             op,
   input  logic [7:0]       in_byte,
   output logic             q_push,
   output jsu_pkg::rec_type q_rec
);
   import jsu_pkg::*;

   typedef enum logic [2:0] {
      PH_WAIT,
      PH_BODY,
      PH_ESC,
      PH_HEX,
      PH_PAIR_BS,
      PH_PAIR_U,
      PH_PAIR_HEX,
      PH_CLOSED
   } phase_type;

   // effect of a body or escape character
   typedef struct packed {
      phase_type  ph;
      logic       chr_v;
      logic [7:0] chr;
      logic       st_v;
      status_type st;
   } act_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] b);
      hex_type h;
      h = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.ok  = 1'b1;
         h.val = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h.ok  = 1'b1;
         h.val = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h.ok  = 1'b1;
         h.val = 4'(b - 8'h37);
      end
      return h;
   endfunction

   function automatic act_type body_act(input logic [7:0] b);
      act_type a;
      a = '{ph: PH_BODY, chr_v: 1'b0, chr: 8'h00, st_v: 1'b0, st: ST_BYTE};
      if (b == CH_QUOTE) begin
         a.ph   = PH_CLOSED;
         a.st_v = 1'b1;
         a.st   = ST_CLOSED;
      end else if (b == CH_BSLASH) begin
         a.ph = PH_ESC;
      end else begin
         a.chr_v = 1'b1;
         a.chr   = b;
      end
      return a;
   endfunction

   function automatic act_type esc_act(input logic [7:0] b);
      act_type a;
      a = '{ph: PH_BODY, chr_v: 1'b1, chr: 8'h00, st_v: 1'b0, st: ST_BYTE};
      unique case (b)
         CH_QUOTE:  a.chr = 8'h22;
         CH_BSLASH: a.chr = 8'h5C;
         CH_SLASH:  a.chr = 8'h2F;
         CH_LOW_B:  a.chr = 8'h08;
         CH_LOW_F:  a.chr = 8'h0C;
         CH_LOW_N:  a.chr = 8'h0A;
         CH_LOW_R:  a.chr = 8'h0D;
         CH_LOW_T:  a.chr = 8'h09;
         CH_LOW_U: begin
            a.ph    = PH_HEX;
            a.chr_v = 1'b0;
         end
         default: begin
            a.ph    = PH_WAIT;
            a.chr_v = 1'b0;
            a.st_v  = 1'b1;
            a.st    = ST_BADESC;
         end
      endcase
      return a;
   endfunction

   localparam utf8_type REPLACE_UTF8 = utf8_encode(CP_REPLACE);

   phase_type   phase_ff, phase_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [11:0] hex_accum_ff, hex_accum_in;
   logic [9:0]  high_half_ff, high_half_in;

   hex_type     hd;
   act_type     body_a, esc_a, act;
   logic        use_act;
   logic [15:0] hex_val;
   logic        val_high, val_low;
   logic [20:0] joined;
   logic        pre;
   utf8_type    main;
   logic        st_v;
   status_type  st;
   rec_type     rec;

   always_comb begin
      hd       = hex_decode(in_byte);
      body_a   = body_act(in_byte);
      esc_a    = esc_act(in_byte);
      hex_val  = {hex_accum_ff, hd.val};
      val_high = hex_val >= CP_HIGH_FIRST && hex_val <= CP_HIGH_LAST;
      val_low  = hex_val >= CP_LOW_FIRST && hex_val <= CP_LOW_LAST;
      joined   = CP_SUPP_BASE + {1'b0, high_half_ff, hex_val[9:0]};

      phase_in     = phase_ff;
      hex_count_in = '0;
      hex_accum_in = '0;
      high_half_in = high_half_ff;
      pre          = 1'b0;
      main         = '0;
      st_v         = 1'b0;
      st           = ST_BYTE;
      act          = body_a;
      use_act      = 1'b0;

      if (op) begin
         // end of text: always back to waiting for a quote
         phase_in     = PH_WAIT;
         high_half_in = '0;
         unique case (phase_ff)
            PH_CLOSED: ;
            PH_BODY, PH_ESC, PH_HEX: begin
               st_v = 1'b1;
               st   = ST_UNTERM;
            end
            PH_PAIR_BS, PH_PAIR_U, PH_PAIR_HEX: begin
               pre  = 1'b1;
               st_v = 1'b1;
               st   = ST_UNTERM;
            end
            PH_WAIT: begin
               st_v = 1'b1;
               st   = ST_NOQUOTE;
            end
         endcase
      end else begin
         unique case (phase_ff)
            PH_WAIT: begin
               if (in_byte == CH_QUOTE) begin
                  phase_in = PH_BODY;
               end else begin
                  st_v = 1'b1;
                  st   = ST_NOQUOTE;
               end
            end
            PH_BODY: begin
               act     = body_a;
               use_act = 1'b1;
            end
            PH_ESC: begin
               act     = esc_a;
               use_act = 1'b1;
            end
            PH_HEX, PH_PAIR_HEX: begin
               if (!hd.ok) begin
                  pre          = (phase_ff == PH_PAIR_HEX);
                  st_v         = 1'b1;
                  st           = ST_BADHEX;
                  phase_in     = PH_WAIT;
                  high_half_in = '0;
               end else if (hex_count_ff != 2'd3) begin
                  hex_accum_in = hex_val[11:0];
                  hex_count_in = hex_count_ff + 2'd1;
               end else if (phase_ff == PH_PAIR_HEX && val_low) begin
                  main         = utf8_encode(joined);
                  phase_in     = PH_BODY;
                  high_half_in = '0;
               end else begin
                  // a broken pair first gives a replacement, then the value again
                  pre = (phase_ff == PH_PAIR_HEX);
                  if (val_high) begin
                     high_half_in = hex_val[9:0];
                     phase_in     = PH_PAIR_BS;
                  end else begin
                     main         = val_low ? REPLACE_UTF8 : utf8_encode({5'b00000, hex_val});
                     high_half_in = '0;
                     phase_in     = PH_BODY;
                  end
               end
            end
            PH_PAIR_BS: begin
               if (in_byte == CH_BSLASH) begin
                  phase_in = PH_PAIR_U;
               end else begin
                  pre          = 1'b1;
                  high_half_in = '0;
                  act          = body_a;
                  use_act      = 1'b1;
               end
            end
            PH_PAIR_U: begin
               if (in_byte == CH_LOW_U) begin
                  phase_in = PH_PAIR_HEX;
               end else begin
                  pre          = 1'b1;
                  high_half_in = '0;
                  act          = esc_a;
                  use_act      = 1'b1;
               end
            end
            PH_CLOSED: begin
               st_v = 1'b1;
               st   = ST_AFTER;
            end
         endcase
      end

      if (use_act) begin
         phase_in = act.ph;
         if (act.chr_v) begin
            main.len  = 3'd1;
            main.b[0] = act.chr;
         end
         st_v = act.st_v;
         st   = act.st;
         if (act.ph == PH_WAIT) begin
            high_half_in = '0;
         end
      end

      rec        = '0;
      rec.has_st = st_v;
      rec.st     = st;
      if (pre) begin
         rec.bytes[2:0] = REPLACE_UTF8.b[2:0];
         rec.bytes[5:3] = main.b[2:0];
         rec.nb         = 3'd3 + main.len;
      end else begin
         rec.bytes[3:0] = main.b;
         rec.nb         = main.len;
      end
   end

   assign q_push = accept && (rec.nb != 3'd0 || rec.has_st);
   assign q_rec  = rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         hex_count_ff <= '0;
         hex_accum_ff <= '0;
         high_half_ff <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         hex_count_ff <= hex_count_in;
         hex_accum_ff <= hex_accum_in;
         high_half_ff <= high_half_in;
      end
   end

endmodule

/* hdl/jsu_queue.sv */
// ----------------------------------------------------------------------------
// jsu_queue
// small record fifo between decoder and serialiser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jsu_queue #(
   parameter int DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::rec_type wr_rec,
   output logic             full,
   input  logic             pop,
   output jsu_pkg::rec_type rd_rec,
   output logic             not_empty
);
   import jsu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rec_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               wr, rd;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign wr        = push && !full;
   assign rd        = pop && not_empty;
   assign rd_rec    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr && !rd) begin
         count_in = count_ff + 1'b1;
      end else if (rd && !wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         slot_ff[wr_ptr_ff] <= wr_rec;
      end
   end

   `JSU_ASSERT_IMPL(a_no_overflow, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `JSU_ASSERT_NEXT(a_count_up, clock, reset, wr && !rd, count_ff == $past(count_ff) + 1'b1)

endmodule

/* hdl/jsu_back.sv */
// ----------------------------------------------------------------------------
// jsu_back
// serialiser: spreads each record into single result entries
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  jsu_pkg::rec_type q_rec,
   input  logic             q_not_empty,
   output logic             q_pop,
   input  logic             pop,
   output logic             empty,
   output logic [7:0]       out_byte,
   output logic [2:0]       status,
   output logic             last_of_run
);
   import jsu_pkg::*;

   rec_type    cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [2:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   status_type status_ff, status_in;
   logic       last_ff, last_in;

   logic [2:0] total;
   logic       is_last, slot_free, take, done_rec, popped;

   assign total     = cur_ff.nb + {2'b00, cur_ff.has_st};
   assign is_last   = (idx_ff == total - 3'd1);
   assign popped    = pop && out_valid_ff;
   assign slot_free = !out_valid_ff || popped;
   assign take      = cur_valid_ff && slot_free;
   assign done_rec  = take && is_last;
   assign q_pop     = q_not_empty && (!cur_valid_ff || done_rec);

   always_comb begin
      cur_in       = q_pop ? q_rec : cur_ff;
      cur_valid_in = q_pop ? 1'b1 : (done_rec ? 1'b0 : cur_valid_ff);
      idx_in       = (q_pop || done_rec) ? 3'd0 : (take ? idx_ff + 3'd1 : idx_ff);
      out_valid_in = take ? 1'b1 : (popped ? 1'b0 : out_valid_ff);
      out_byte_in  = out_byte_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      if (take) begin
         last_in = is_last;
         if (idx_ff < cur_ff.nb) begin
            out_byte_in = cur_ff.bytes[idx_ff];
            status_in   = ST_BYTE;
         end else begin
            out_byte_in = 8'h00;
            status_in   = cur_ff.st;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      status_ff   <= status_in;
      last_ff     <= last_in;
   end

   assign empty       = !out_valid_ff;
   assign out_byte    = out_byte_ff;
   assign status      = status_ff;
   assign last_of_run = last_ff;

   `JSU_ASSERT_IMPL(a_rec_not_void, clock, reset, cur_valid_ff, total != 3'd0)
   `JSU_ASSERT_IMPL(a_idx_in_range, clock, reset, cur_valid_ff, idx_ff < total)

endmodule

/* hdl/json_string_unescape_to_utf8.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_to_utf8
// json string literal unescaper with utf-8 output
// ----------------------------------------------------------------------------
//  channel   | ports                              | direction
//  ----------+------------------------------------+----------
//  request   | push, full, req_op, req_in_byte    | in
//  result    | pop, empty, rsp_out_byte,          | out
//            | rsp_status, rsp_last_of_run        |
//
//  one request is taken each cycle while full is low; each request gives 0 to 6
//  results, delivered one a cycle while pop is high, so sustained rate is set by the result count
//  the first result reaches the ports through the record queue slot, then the
//  record register, then the output register
//  reset is synchronous and active high, and returns to waiting for a quote
//  full rises only when the record queue fills; empty and pop stall independently
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_string_unescape_to_utf8 #(
   parameter int QUEUE_DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   // request side
   input  logic       push,
   output logic       full,
   input  logic       req_op,
   input  logic [7:0] req_in_byte,
   // result side
   input  logic       pop,
   output logic       empty,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_status,
   output logic       rsp_last_of_run
);
   import jsu_pkg::*;

   logic    accept;
   logic    q_push, q_full, q_pop, q_not_empty;
   rec_type front_rec, head_rec;

   // a request is taken whenever the queue has room for its record
   assign full   = q_full;
   assign accept = push && !q_full;

   // decoder: tracks the escape state and folds each request into one record
   jsu_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .op      (req_op),
      .in_byte (req_in_byte),
      .q_push  (q_push),
      .q_rec   (front_rec)
   );

   // records that give no result never enter the queue
   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wr_rec    (front_rec),
      .full      (q_full),
      .pop       (q_pop),
      .rd_rec    (head_rec),
      .not_empty (q_not_empty)
   );

   // serialiser: one result entry per cycle into the output register while it is free or popped
   jsu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_rec       (head_rec),
      .q_not_empty (q_not_empty),
      .q_pop       (q_pop),
      .pop         (pop),
      .empty       (empty),
      .out_byte    (rsp_out_byte),
      .status      (rsp_status),
      .last_of_run (rsp_last_of_run)
   );

endmodule

/* dv/json_string_unescape_to_utf8_test.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_to_utf8_test
// self-checking bench for the json string unescaper with utf-8 output
// ----------------------------------------------------------------------------
// bytes of json string literals go in as requests
// an in-bench decoder predicts the results of each accepted request
// every popped result is checked field by field against the oldest prediction
// directed tests for plain bytes, escapes, code points, pairs, errors and ends
// random strings follow, mostly well formed, mixed with noise and broken escapes
// the sender idles in bursts, the receiver stalls on a pattern of its own
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_string_unescape_to_utf8_test;
   import jsu_pkg::*;

   // request codes
   localparam logic OP_DATA = 1'b0;
   localparam logic OP_END  = 1'b1;

   // characters the bench needs beyond those of the package
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;

   // control bytes that the short escapes stand for
   localparam logic [7:0] CTRL_BACKSPACE = 8'h08;
   localparam logic [7:0] CTRL_TAB       = 8'h09;
   localparam logic [7:0] CTRL_NEWLINE   = 8'h0A;
   localparam logic [7:0] CTRL_FORMFEED  = 8'h0C;
   localparam logic [7:0] CTRL_RETURN    = 8'h0D;

   localparam int          RANDOM_REQUESTS = 240;
   localparam int          DRAIN_CYCLES    = 12;
   // the limit allows for about 500 requests at worst 6 results each, with receiver stalls
   // and sender gaps
   localparam int unsigned CYCLE_LIMIT     = 300_000;

   // where the decoder stands within a string literal
   typedef enum logic [2:0] {
      PH_WAIT,       // before the opening quote
      PH_BODY,       // inside the string
      PH_ESC,        // after a backslash
      PH_HEX,        // gathering the digits of \u
      PH_PAIR_BS,    // high surrogate held, backslash expected
      PH_PAIR_U,     // high surrogate held, u expected
      PH_PAIR_HEX,   // high surrogate held, gathering the second unit
      PH_CLOSED      // closing quote seen
   } scan_phase_type;

   // receiver stall patterns
   typedef enum logic [1:0] {
      RX_FREE,
      RX_THIRDS,
      RX_COIN,
      RX_LONG
   } rx_mode_type;

   typedef struct packed {
      logic [7:0] data;
      status_type status;
      logic       is_last;
   } utf8_result_type;

   logic       clock;
   logic       reset       = 1'b1;
   logic       push        = 1'b0;
   logic       full;
   logic       req_op      = OP_DATA;
   logic [7:0] req_in_byte = 8'h00;
   logic       pop         = 1'b0;
   logic       empty;
   logic [7:0] rsp_out_byte;
   logic [2:0] rsp_status;
   logic       rsp_last_of_run;

   // decoder state of the prediction
   scan_phase_type scan_phase   = PH_WAIT;
   logic [1:0]     digit_count  = '0;
   logic [15:0]    digit_value  = '0;
   logic [9:0]     pending_high = '0;

   utf8_result_type request_results[$];   // results of the request being decoded
   utf8_result_type decoded_queue[$];     // predicted results not yet popped

   int          error_count    = 0;
   int          requests_sent  = 0;
   int          burst_left     = 0;
   int unsigned cycle_count    = 0;

   json_string_unescape_to_utf8 dut (
      .clock,
      .reset,
      .push,
      .full,
      .req_op,
      .req_in_byte,
      .pop,
      .empty,
      .rsp_out_byte,
      .rsp_status,
      .rsp_last_of_run
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   function automatic void add_result(input logic [7:0] b, input status_type s);
      utf8_result_type r;
      r = '{data: b, status: s, is_last: 1'b0};
      request_results.insert(request_results.size(), r);
   endfunction

   // utf-8 encoding of one code point, one to four bytes
   function automatic void add_code_point(input logic [20:0] cp);
      if (cp <= CP_ONE_MAX) begin
         add_result(cp[7:0], ST_BYTE);
      end else if (cp <= CP_TWO_MAX) begin
         add_result(U8_LEAD2 | {3'b000, cp[10:6]}, ST_BYTE);
         add_result(U8_CONT | {2'b00, cp[5:0]}, ST_BYTE);
      end else if (cp <= CP_THREE_MAX) begin
         add_result(U8_LEAD3 | {4'b0000, cp[15:12]}, ST_BYTE);
         add_result(U8_CONT | {2'b00, cp[11:6]}, ST_BYTE);
         add_result(U8_CONT | {2'b00, cp[5:0]}, ST_BYTE);
      end else begin
         add_result(U8_LEAD4 | {5'b00000, cp[20:18]}, ST_BYTE);
         add_result(U8_CONT | {2'b00, cp[17:12]}, ST_BYTE);
         add_result(U8_CONT | {2'b00, cp[11:6]}, ST_BYTE);
         add_result(U8_CONT | {2'b00, cp[5:0]}, ST_BYTE);
      end
   endfunction

   // value of a hex digit of either case, or -1
   function automatic int hex_nibble(input logic [7:0] b);
      if (b >= CH_ZERO && b <= CH_NINE) return int'(b - CH_ZERO);
      if (b >= CH_LOW_A && b <= CH_LOW_F) return int'(b - CH_LOW_A) + 10;
      if (b >= CH_UP_A && b <= CH_UP_F) return int'(b - CH_UP_A) + 10;
      return -1;
   endfunction

   function automatic void return_to_wait();
      scan_phase   = PH_WAIT;
      digit_count  = '0;
      digit_value  = '0;
      pending_high = '0;
   endfunction

   function automatic void string_byte(input logic [7:0] b);
      if (b == CH_QUOTE) begin
         add_result(8'h00, ST_CLOSED);
         scan_phase = PH_CLOSED;
      end else if (b == CH_BSLASH) begin
         scan_phase = PH_ESC;
      end else begin
         add_result(b, ST_BYTE);
      end
   endfunction

   function automatic void escape_letter(input logic [7:0] b);
      logic [7:0] c;
      case (b)
         CH_QUOTE:  c = CH_QUOTE;
         CH_BSLASH: c = CH_BSLASH;
         CH_SLASH:  c = CH_SLASH;
         CH_LOW_B:  c = CTRL_BACKSPACE;
         CH_LOW_F:  c = CTRL_FORMFEED;
         CH_LOW_N:  c = CTRL_NEWLINE;
         CH_LOW_R:  c = CTRL_RETURN;
         CH_LOW_T:  c = CTRL_TAB;
         CH_LOW_U: begin
            scan_phase  = PH_HEX;
            digit_count = '0;
            digit_value = '0;
            return;
         end
         default: begin
            add_result(8'h00, ST_BADESC);
            return_to_wait();
            return;
         end
      endcase
      add_result(c, ST_BYTE);
      scan_phase = PH_BODY;
   endfunction

   // a complete first \u unit: either a character or a held high surrogate
   function automatic void take_unit(input logic [15:0] v);
      digit_count = '0;
      digit_value = '0;
      if (v >= CP_HIGH_FIRST && v <= CP_HIGH_LAST) begin
         pending_high = v[9:0];
         scan_phase   = PH_PAIR_BS;
         return;
      end
      if (v >= CP_LOW_FIRST && v <= CP_LOW_LAST) add_code_point(CP_REPLACE);
      else add_code_point({5'b00000, v});
      scan_phase = PH_BODY;
   endfunction

   function automatic void scan_data(input logic [7:0] b);
      int          nib;
      logic [15:0] unit;
      case (scan_phase)
         PH_WAIT: begin
            if (b == CH_QUOTE) scan_phase = PH_BODY;
            else add_result(8'h00, ST_NOQUOTE);
         end
         PH_BODY: string_byte(b);
         PH_ESC:  escape_letter(b);
         PH_HEX, PH_PAIR_HEX: begin
            nib = hex_nibble(b);
            if (nib < 0) begin
               if (scan_phase == PH_PAIR_HEX) add_code_point(CP_REPLACE);
               add_result(8'h00, ST_BADHEX);
               return_to_wait();
            end else begin
               unit = {digit_value[11:0], nib[3:0]};
               if (digit_count < 2'd3) begin
                  digit_value = unit;
                  digit_count = digit_count + 2'd1;
               end else if (scan_phase == PH_HEX) begin
                  take_unit(unit);
               end else if (unit >= CP_LOW_FIRST && unit <= CP_LOW_LAST) begin
                  // a low half below a held high half: one supplementary point
                  add_code_point(CP_SUPP_BASE + {1'b0, pending_high, unit[9:0]});
                  digit_count  = '0;
                  digit_value  = '0;
                  pending_high = '0;
                  scan_phase   = PH_BODY;
               end else begin
                  // not a low half: replace the lone high, decode the unit afresh
                  add_code_point(CP_REPLACE);
                  pending_high = '0;
                  take_unit(unit);
               end
            end
         end
         PH_PAIR_BS: begin
            if (b == CH_BSLASH) begin
               scan_phase = PH_PAIR_U;
            end else begin
               add_code_point(CP_REPLACE);
               pending_high = '0;
               scan_phase   = PH_BODY;
               string_byte(b);
            end
         end
         PH_PAIR_U: begin
            if (b == CH_LOW_U) begin
               scan_phase  = PH_PAIR_HEX;
               digit_count = '0;
               digit_value = '0;
            end else begin
               add_code_point(CP_REPLACE);
               pending_high = '0;
               escape_letter(b);
            end
         end
         default: add_result(8'h00, ST_AFTER);
      endcase
   endfunction

   function automatic void scan_end();
      case (scan_phase)
         PH_CLOSED: ;
         PH_BODY, PH_ESC, PH_HEX: add_result(8'h00, ST_UNTERM);
         PH_PAIR_BS, PH_PAIR_U, PH_PAIR_HEX: begin
            add_code_point(CP_REPLACE);
            add_result(8'h00, ST_UNTERM);
         end
         default: add_result(8'h00, ST_NOQUOTE);
      endcase
      return_to_wait();
   endfunction

   // works out the results of one accepted request and queues them
   function automatic void decode_request(input logic op, input logic [7:0] b);
      request_results.delete();
      if (op == OP_END) scan_end();
      else scan_data(b);
      if (request_results.size() > 0)
         request_results[request_results.size() - 1].is_last = 1'b1;
      foreach (request_results[i])
         decoded_queue.insert(decoded_queue.size(), request_results[i]);
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   // one request, held until accepted; gaps fall between random-length bursts
   task automatic send_request(input logic op, input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         // a third of the bursts follow on with no gap at all
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      push        <= 1'b1;
      req_op      <= op;
      req_in_byte <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      decode_request(op, b);
      requests_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_request(OP_DATA, s[i]);
   endtask

   // a digit of either case for a random nibble
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return CH_ZERO + {4'h0, n};
      return (($urandom_range(0, 1) == 1) ? CH_LOW_A : CH_UP_A) + {4'h0, n} - 8'd10;
   endfunction

   task automatic send_u_escape(input logic [15:0] v);
      send_request(OP_DATA, CH_BSLASH);
      send_request(OP_DATA, CH_LOW_U);
      for (int k = 3; k >= 0; k--) send_request(OP_DATA, hex_char(v[k*4 +: 4]));
   endtask

   // ------------------------------------------------------------------------
   // random content
   // ------------------------------------------------------------------------

   function automatic logic [7:0] random_plain();
      logic [7:0] b;
      b = 8'($urandom);
      if (b == CH_QUOTE || b == CH_BSLASH) b = CH_LOW_A;
      return b;
   endfunction

   function automatic logic [7:0] random_non_hex();
      logic [7:0] b;
      do b = 8'($urandom); while (hex_nibble(b) >= 0);
      return b;
   endfunction

   function automatic logic [7:0] random_escape_letter();
      case ($urandom_range(0, 7))
         0: return CH_QUOTE;
         1: return CH_BSLASH;
         2: return CH_SLASH;
         3: return CH_LOW_B;
         4: return CH_LOW_F;
         5: return CH_LOW_N;
         6: return CH_LOW_R;
         default: return CH_LOW_T;
      endcase
   endfunction

   function automatic logic [7:0] random_bad_letter();
      logic [7:0] b;
      do b = 8'($urandom);
      while (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == CH_LOW_B ||
             b == CH_LOW_F || b == CH_LOW_N || b == CH_LOW_R || b == CH_LOW_T ||
             b == CH_LOW_U);
      return b;
   endfunction

   // a unit that is no surrogate, spread over the utf-8 lengths
   function automatic logic [15:0] random_bmp();
      case ($urandom_range(0, 4))
         0: return 16'($urandom_range(32'h0000, 32'h007F));
         1: return 16'($urandom_range(32'h0080, 32'h07FF));
         2: return 16'($urandom_range(32'h0800, 32'hD7FF));
         3: return 16'($urandom_range(32'hE000, 32'hFFFF));
         default: begin
            // boundaries between the encoding lengths
            case ($urandom_range(0, 5))
               0: return 16'h0000;
               1: return 16'h007F;
               2: return 16'h0080;
               3: return 16'h07FF;
               4: return 16'h0800;
               default: return 16'hFFFF;
            endcase
         end
      endcase
   endfunction

   function automatic logic [15:0] random_high();
      return CP_HIGH_FIRST + 16'($urandom_range(0, 32'h3FF));
   endfunction

   function automatic logic [15:0] random_low();
      return CP_LOW_FIRST + 16'($urandom_range(0, 32'h3FF));
   endfunction

   // one string literal, mostly well formed, or else noise; broken escapes or an early end of text end it early
   task automatic send_random_string();
      int tokens;
      int digits;
      if ($urandom_range(0, 9) == 0) begin
         // noise outside any string
         repeat ($urandom_range(1, 6))
            send_request(($urandom_range(0, 7) == 0) ? OP_END : OP_DATA, 8'($urandom));
         send_request(OP_END, 8'($urandom));
         return;
      end
      send_request(OP_DATA, CH_QUOTE);
      tokens = $urandom_range(0, 10);
      repeat (tokens) begin
         case ($urandom_range(0, 39))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13:
               send_request(OP_DATA, random_plain());
            14, 15, 16, 17, 18: begin
               send_request(OP_DATA, CH_BSLASH);
               send_request(OP_DATA, random_escape_letter());
            end
            19, 20, 21, 22, 23: send_u_escape(random_bmp());
            24, 25, 26, 27: begin
               send_u_escape(random_high());
               send_u_escape(random_low());
            end
            28: send_u_escape(random_low());
            29, 30: begin
               // held high half, then a plain byte
               send_u_escape(random_high());
               send_request(OP_DATA, random_plain());
            end
            31, 32: begin
               // held high half, then an escape other than \u
               send_u_escape(random_high());
               send_request(OP_DATA, CH_BSLASH);
               if ($urandom_range(0, 3) == 0) begin
                  send_request(OP_DATA, random_bad_letter());
                  return;
               end
               send_request(OP_DATA, random_escape_letter());
            end
            33, 34: begin
               // held high half, then a unit that is no low half
               send_u_escape(random_high());
               send_u_escape(($urandom_range(0, 2) == 0) ? random_high() : random_bmp());
            end
            35: begin
               send_u_escape(random_high());
               send_request(OP_DATA, CH_BSLASH);
               send_request(OP_DATA, CH_LOW_U);
               repeat ($urandom_range(0, 3)) send_request(OP_DATA, hex_char(4'($urandom)));
               send_request(OP_DATA, random_non_hex());
               return;
            end
            36: begin
               send_request(OP_DATA, CH_BSLASH);
               send_request(OP_DATA, random_bad_letter());
               return;
            end
            37: begin
               send_request(OP_DATA, CH_BSLASH);
               send_request(OP_DATA, CH_LOW_U);
               digits = $urandom_range(0, 3);
               repeat (digits) send_request(OP_DATA, hex_char(4'($urandom)));
               send_request(OP_DATA, random_non_hex());
               return;
            end
            38: begin
               send_request(OP_END, 8'($urandom));
               return;
            end
            default: begin
               send_u_escape(random_high());
               send_request(OP_END, 8'($urandom));
               return;
            end
         endcase
      end
      send_request(OP_DATA, CH_QUOTE);
      repeat ($urandom_range(0, 2)) send_request(OP_DATA, 8'($urandom));
      send_request(OP_END, 8'($urandom));
   endtask

   // ------------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------------

   function automatic void note_mismatch(input string field, input logic [7:0] want,
                                         input logic [7:0] got);
      error_count++;
      $display("%0t: %s mismatch, expected %02h actual %02h", $time, field, want, got);
   endfunction

   task automatic check_output();
      utf8_result_type want;
      if (decoded_queue.size() == 0) begin
         error_count++;
         $display("%0t: result with nothing expected, actual byte %02h status %0d last %0b",
                  $time, rsp_out_byte, rsp_status, rsp_last_of_run);
         return;
      end
      want = decoded_queue.pop_front();
      if (rsp_out_byte !== want.data) note_mismatch("out_byte", want.data, rsp_out_byte);
      if (rsp_status !== want.status)
         note_mismatch("status", {5'b00000, want.status}, {5'b00000, rsp_status});
      if (rsp_last_of_run !== want.is_last)
         note_mismatch("last_of_run", {7'b0, want.is_last}, {7'b0, rsp_last_of_run});
   endtask

   // outputs are read just after the edge, so they hold their pre-edge values;
   // pop follows a stall pattern that is chosen anew at random over the run
   initial begin : result_checker
      rx_mode_type rx_mode;
      int          mode_cycles;
      int          tick;
      rx_mode     = RX_FREE;
      mode_cycles = 0;
      tick        = 0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) check_output();
         tick++;
         if (mode_cycles == 0) begin
            rx_mode     = rx_mode_type'($urandom_range(0, 3));
            mode_cycles = $urandom_range(20, 80);
         end
         mode_cycles--;
         if (reset) begin
            pop <= 1'b0;
         end else begin
            case (rx_mode)
               RX_FREE:   pop <= 1'b1;
               RX_THIRDS: pop <= (tick % 3) != 0;
               RX_COIN:   pop <= 1'($urandom_range(0, 1));
               default:   pop <= (tick % 16) >= 10;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // no quote yet: bytes at both extremes and end of text while waiting
   task automatic test_outside_string();
      send_request(OP_END, 8'h00);
      send_request(OP_DATA, 8'h00);
      send_request(OP_DATA, 8'hFF);
      send_request(OP_END, 8'hFF);
   endtask

   // plain bytes, every short escape, close, a byte after close, then end
   task automatic test_plain_and_escapes();
      send_request(OP_DATA, CH_QUOTE);
      send_request(OP_DATA, 8'h00);
      send_request(OP_DATA, 8'hFF);
      send_text("A\\\"\\\\\\/\\b\\f\\n\\r\\t\"x");
      send_request(OP_END, 8'h00);
   endtask

   // one to four byte code points, joined pairs, a lone low half
   task automatic test_unicode_escapes();
      send_text("\"\\u0041\\u00e9\\u07FF\\u20ac\\uFFFF\\uD83D\\ude00\\uDBFF\\uDFFF\\uDC00\"");
      send_request(OP_END, 8'h00);
   endtask

   // a held high half followed by anything but its low half
   task automatic test_broken_pairs();
      // plain byte, then the closing quote
      send_text("\"\\uD800z\\uD800\"");
      send_request(OP_END, 8'h00);
      // short escape, a unit that is no low half, a second high half
      send_text("\"\\uD801\\n\\uD802\\u0041\\uD803\\uDBFE\\uDC01\"");
      send_request(OP_END, 8'h00);
      // bad escape letter after the backslash
      send_text("\"\\uD804\\q");
      // bad digit in the second unit
      send_text("\"\\uD805\\u12g");
   endtask

   // errors inside the string and end of text in every phase inside the string
   task automatic test_errors_and_ends();
      send_text("\"\\q");
      send_text("\"\\u1x");
      send_text("\"ab");
      send_request(OP_END, 8'h00);
      send_text("\"\\");
      send_request(OP_END, 8'h00);
      send_text("\"\\u12");
      send_request(OP_END, 8'h00);
      send_text("\"\\uD806");
      send_request(OP_END, 8'h00);
      send_text("\"\\uD807\\");
      send_request(OP_END, 8'h00);
      send_text("\"\\uD808\\u1");
      send_request(OP_END, 8'h00);
   endtask

   task automatic test_random_strings();
      int target;
      target = requests_sent + RANDOM_REQUESTS;
      while (requests_sent < target) send_random_string();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_outside_string();
      test_plain_and_escapes();
      test_unicode_escapes();
      test_broken_pairs();
      test_errors_and_ends();
      test_random_strings();
      push <= 1'b0;
      // wait for every predicted result, then make sure nothing more turns up
      while (decoded_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (decoded_queue.size() != 0) begin
         error_count++;
         $display("%0t: %0d results never arrived", $time, decoded_queue.size());
      end
      if (error_count == 0) begin
         $display("json_string_unescape_to_utf8 test passed");
      end else begin
         $display("json_string_unescape_to_utf8 test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("json_string_unescape_to_utf8 test failed");
      $finish;
   end

endmodule
